### sv/rbmf_pkg.sv
// Shared types, constants and register indexes of the RGB box mean filter.
package rbmf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_KERNEL = 15;

    localparam int COL_MAX_W  = 12;
    localparam int SLOT_MAX_W = 5;
    localparam int K_W        = 5;

    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [3:0]  KERNEL_RESET = 4'd3;
    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam logic [12:0] MAX_HEIGHT   = 13'd4096;

    typedef struct packed {
        logic [23:0]           pixel;
        logic [COL_MAX_W-1:0]  col;
        logic [SLOT_MAX_W-1:0] slot;
        logic [K_W-1:0]        k;
        logic                  emit;
        logic                  last;
        logic [9:0]            center_col;
        logic [11:0]           center_row;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_LAST,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

### sv/rbmf_front.sv
// Front end: configuration registers, pixel position tracking and item classification.
module rbmf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [12:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    input  logic              frame_start,
    input  logic              q_full,
    output logic              q_push,
    output rbmf_pkg::job_t    q_job
);
    import rbmf_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SLOT_W = $clog2(MAX_KERNEL);
    localparam int KMAX   = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;

    logic [3:0]        kernel_reg;
    logic [10:0]       width_reg;
    logic [12:0]       height_reg;
    logic [COL_W-1:0]  col_count_reg, col_count_next;
    logic [11:0]       row_count_reg, row_count_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [COL_W-1:0]  col;
    logic [11:0]       row;
    logic [SLOT_W-1:0] slot;
    logic [12:0]       eff_w, eff_h, col_ext, row_ext, k_ext;
    logic [K_W-1:0]    k;
    logic              end_col, end_row, accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign q_push    = accept;

    always_comb
    begin
        if (kernel_reg < 4'd3)
            k = K_W'(3);
        else if (!kernel_reg[0])
            k = K_W'(kernel_reg) - K_W'(1);
        else
            k = K_W'(kernel_reg);
        if (k > K_W'(KMAX))
            k = K_W'(KMAX);

        eff_w = {2'b0, width_reg};
        if (eff_w == 13'd0)
            eff_w = 13'd1;
        else if (eff_w > 13'(MAX_WIDTH))
            eff_w = 13'(MAX_WIDTH);

        eff_h = height_reg;
        if (eff_h == 13'd0)
            eff_h = 13'd1;
        else if (eff_h > MAX_HEIGHT)
            eff_h = MAX_HEIGHT;
    end

    always_comb
    begin
        col  = frame_start ? '0 : col_count_reg;
        row  = frame_start ? '0 : row_count_reg;
        slot = frame_start ? '0 : slot_reg;

        col_ext = 13'(col);
        row_ext = {1'b0, row};
        k_ext   = 13'(k);
        end_col = (col_ext + 13'd1 >= eff_w);
        end_row = (row_ext + 13'd1 >= eff_h);

        q_job.pixel      = {red_in, green_in, blue_in};
        q_job.col        = COL_MAX_W'(col);
        q_job.slot       = SLOT_MAX_W'(slot);
        q_job.k          = k;
        q_job.emit       = (k_ext <= eff_w) && (k_ext <= eff_h)
                           && (col_ext + 13'd1 >= k_ext) && (row_ext + 13'd1 >= k_ext);
        q_job.last       = end_col && end_row;
        q_job.center_col = 10'(col_ext - 13'(k >> 1));
        q_job.center_row = row - 12'(k >> 1);

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        slot_next      = slot_reg;
        if (accept)
        begin
            if (end_col)
            begin
                col_count_next = '0;
                if (end_row)
                begin
                    row_count_next = '0;
                    slot_next      = '0;
                end
                else
                begin
                    row_count_next = row + 12'd1;
                    slot_next      = (slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot + SLOT_W'(1);
                end
            end
            else
            begin
                col_count_next = col + COL_W'(1);
                row_count_next = row;
                slot_next      = slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg    <= KERNEL_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KERNEL: kernel_reg <= cfg_data[3:0];
                    REG_WIDTH:  width_reg  <= cfg_data[10:0];
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            slot_reg      <= slot_next;
        end
    end

endmodule

### sv/rbmf_queue.sv
// Two-entry item queue between the front end and the back end.
module rbmf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rbmf_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output rbmf_pkg::job_t head
);
    import rbmf_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### sv/rbmf_back.sv
// Back end: line store, window summation, mean division and output register.
module rbmf_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 15
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  rbmf_pkg::job_t q_head,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     red_mean,
    output logic [7:0]     green_mean,
    output logic [7:0]     blue_mean,
    output logic [9:0]     center_col,
    output logic [11:0]    center_row,
    output logic           frame_last
);
    import rbmf_pkg::*;

    localparam int KMAX   = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
    localparam int DEPTH  = MAX_KERNEL * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = $clog2(KMAX * KMAX * 255 + 1);
    localparam int AREA_W = $clog2(KMAX * KMAX + 1);
    localparam int CNT_W  = $clog2(SUM_W + 1);

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;
    logic        rd_valid_reg;

    back_state_t           state_reg, state_next;
    job_t                  job_reg, job_next;
    logic [K_W-1:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic [SLOT_MAX_W-1:0] slot_reg, slot_next;
    logic [AREA_W-1:0]     area_reg, area_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SUM_W-1:0]      acc_reg [3];
    logic [SUM_W-1:0]      acc_next [3];
    logic [AREA_W-1:0]     rem_reg [3];
    logic [AREA_W-1:0]     rem_next [3];

    logic              rd_en, load_out, last_read;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [COL_MAX_W-1:0] rd_col;
    logic [AREA_W:0]   trial [3];
    logic [7:0]        chan [3];

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [9:0]  ccol_reg;
    logic [11:0] crow_reg;
    logic        last_reg;

    assign last_read = (dx_reg == job_reg.k - K_W'(1)) && (dy_reg == job_reg.k - K_W'(1));
    assign rd_col    = job_reg.col - COL_MAX_W'(dx_reg);
    assign wr_addr   = ADDR_W'(ADDR_W'(q_head.slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(q_head.col));
    assign rd_addr   = ADDR_W'(ADDR_W'(slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col));
    assign chan[0]   = rd_data_reg[23:16];
    assign chan[1]   = rd_data_reg[15:8];
    assign chan[2]   = rd_data_reg[7:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && q_head.emit)
                    state_next = B_READ;
            end
            B_READ:
            begin
                if (last_read)
                    state_next = B_LAST;
            end
            B_LAST:  state_next = B_DIV;
            B_DIV:
            begin
                if (cnt_reg == CNT_W'(SUM_W - 1))
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (load_out)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = (state_reg == B_IDLE) && !q_empty;
        rd_en    = (state_reg == B_READ);
        load_out = (state_reg == B_OUT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        job_next  = job_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        slot_next = slot_reg;
        area_next = area_reg;
        cnt_next  = cnt_reg;
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = acc_reg[c];
            rem_next[c] = rem_reg[c];
            trial[c]    = {rem_reg[c], acc_reg[c][SUM_W-1]};
        end

        if (q_pop)
        begin
            job_next  = q_head;
            dx_next   = '0;
            dy_next   = '0;
            slot_next = q_head.slot;
            area_next = AREA_W'((2*K_W)'(q_head.k) * (2*K_W)'(q_head.k));
            for (int c = 0; c < 3; c++)
                acc_next[c] = '0;
        end

        if (rd_en)
        begin
            if (dx_reg == job_reg.k - K_W'(1))
            begin
                dx_next   = '0;
                dy_next   = dy_reg + K_W'(1);
                slot_next = (slot_reg == '0) ? SLOT_MAX_W'(MAX_KERNEL - 1)
                                             : slot_reg - SLOT_MAX_W'(1);
            end
            else
                dx_next = dx_reg + K_W'(1);
        end

        if (rd_valid_reg)
        begin
            for (int c = 0; c < 3; c++)
                acc_next[c] = acc_reg[c] + SUM_W'(chan[c]);
        end

        if (state_reg == B_LAST)
        begin
            cnt_next = '0;
            for (int c = 0; c < 3; c++)
                rem_next[c] = '0;
        end

        if (state_reg == B_DIV)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            for (int c = 0; c < 3; c++)
            begin
                if (trial[c] >= (AREA_W+1)'(area_reg))
                begin
                    rem_next[c] = AREA_W'(trial[c] - (AREA_W+1)'(area_reg));
                    acc_next[c] = {acc_reg[c][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = AREA_W'(trial[c]);
                    acc_next[c] = {acc_reg[c][SUM_W-2:0], 1'b0};
                end
            end
        end

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            mem[wr_addr] <= q_head.pixel;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        slot_reg <= slot_next;
        area_reg <= area_next;
        cnt_reg  <= cnt_next;
        for (int c = 0; c < 3; c++)
        begin
            acc_reg[c] <= acc_next[c];
            rem_reg[c] <= rem_next[c];
        end
        if (load_out)
        begin
            red_reg   <= acc_reg[0][7:0];
            green_reg <= acc_reg[1][7:0];
            blue_reg  <= acc_reg[2][7:0];
            ccol_reg  <= job_reg.center_col;
            crow_reg  <= job_reg.center_row;
            last_reg  <= job_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_mean   = red_reg;
    assign green_mean = green_reg;
    assign blue_mean  = blue_reg;
    assign center_col = ccol_reg;
    assign center_row = crow_reg;
    assign frame_last = last_reg;

endmodule

### sv/rgb_box_mean_filter_top.sv
// Top level of the RGB box mean filter.
//
// Channel  Direction  Handshake                Payload
// cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
// in       in         in_valid / in_ready      red_in, green_in, blue_in, frame_start
// out      out        out_valid / out_ready    red_mean, green_mean, blue_mean,
//                                              center_col, center_row, frame_last
//
// The front end takes one pixel per cycle while its two-entry queue has room.
// The back end pops a pixel without a result from the queue and stays idle. For a pixel with a
// result it reads the k*k window through the single line store read port and then runs the
// bit-serial divider (SUM_W is 16 for a largest kernel of 15) before it pops the next pixel.
// Reset clears the position counters, queue and output valid flag; the result registers and line store are not cleared.
// A stalled output holds the back end, which then fills the queue and lowers in_ready.
module rgb_box_mean_filter_top #(
    parameter int MAX_WIDTH  = rbmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = rbmf_pkg::DEF_MAX_KERNEL
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_mean,
    output logic [7:0]  green_mean,
    output logic [7:0]  blue_mean,
    output logic [9:0]  center_col,
    output logic [11:0] center_row,
    output logic        frame_last
);
    import rbmf_pkg::*;

    job_t push_job, head;
    logic push, pop, full, empty;

    rbmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .frame_start (frame_start),
        .q_full      (full),
        .q_push      (push),
        .q_job       (push_job)
    );

    rbmf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    rbmf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (empty),
        .q_head     (head),
        .q_pop      (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_mean   (red_mean),
        .green_mean (green_mean),
        .blue_mean  (blue_mean),
        .center_col (center_col),
        .center_row (center_row),
        .frame_last (frame_last)
    );

endmodule

### sv/rbmf_checker.sv
// Port-level checks of the RGB box mean filter and their binding to the top level.
module rbmf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  red_mean,
    input logic [7:0]  green_mean,
    input logic [7:0]  blue_mean,
    input logic [9:0]  center_col,
    input logic [11:0] center_row,
    input logic        frame_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_mean) && $stable(green_mean)
            && $stable(blue_mean) && $stable(center_col) && $stable(center_row)
            && $stable(frame_last))
        else $error("Result changed while stalled.");

    a_reset_out: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
        else $error("Result shown right after reset.");

    a_reset_in: assert property (@(posedge clk) $past(!rst_n) |-> in_ready)
        else $error("Input not ready right after reset.");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("Configuration port not ready.");

endmodule

bind rgb_box_mean_filter_top rbmf_checker u_checker (.*);

### dv/rgb_box_mean_filter_top_test.sv
// Self-checking testbench for the RGB box mean filter against a window-sum predictor.
`timescale 1ns / 100ps

module rgb_box_mean_filter_top_test;
    import rbmf_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       first;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [9:0]  col;
        logic [11:0] row;
        logic        last;
    } window_mean_t;

    localparam int STORE_LINES = 15;
    localparam int STORE_COLS  = 1024;
    localparam int STALL_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_KERNEL;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic        frame_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  red_mean;
    logic [7:0]  green_mean;
    logic [7:0]  blue_mean;
    logic [9:0]  center_col;
    logic [11:0] center_row;
    logic        frame_last;

    pixel_item_t  pending_pixels[$];
    window_mean_t expected_means[$];
    int           idle_pct = 17;
    int           error_count = 0;
    int           results_seen = 0;
    int           rx_hold_left = 0;
    bit           rx_hold_done = 1'b0;
    int           quiet_cycles = 0;

    logic [3:0]   model_kernel = KERNEL_RESET;
    logic [10:0]  model_width = WIDTH_RESET;
    logic [12:0]  model_height = HEIGHT_RESET;
    logic [23:0]  line_pixels[STORE_LINES][STORE_COLS];
    int           next_col = 0;
    int           next_row = 0;

    rgb_box_mean_filter_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .frame_start(frame_start),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_mean   (red_mean),
        .green_mean (green_mean),
        .blue_mean  (blue_mean),
        .center_col (center_col),
        .center_row (center_row),
        .frame_last (frame_last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void predict_window_mean(input pixel_item_t px);
        int k;
        int w;
        int h;
        int col;
        int row;
        int sr;
        int sg;
        int sb;
        int slot;
        logic [23:0] p;
        bit end_col;
        bit end_row;
        window_mean_t m;
        k = model_kernel < 3 ? 3 : (model_kernel % 2 == 0 ? model_kernel - 1 : model_kernel);
        if (k > 15)
        begin
            k = 15;
        end
        w = model_width < 1 ? 1 : (model_width > 1024 ? 1024 : model_width);
        h = model_height < 1 ? 1 : (model_height > 4096 ? 4096 : model_height);
        if (px.first)
        begin
            next_col = 0;
            next_row = 0;
        end
        col = next_col % STORE_COLS;
        row = next_row;
        end_col = (col + 1 >= w);
        end_row = (row + 1 >= h);
        line_pixels[row % STORE_LINES][col] = {px.red, px.green, px.blue};
        if (k <= w && k <= h && col + 1 >= k && row + 1 >= k)
        begin
            sr = 0;
            sg = 0;
            sb = 0;
            for (int dy = 0; dy < k; dy++)
            begin
                slot = (row - dy) % STORE_LINES;
                for (int dx = 0; dx < k; dx++)
                begin
                    p = line_pixels[slot][col - dx];
                    sr += p[23:16];
                    sg += p[15:8];
                    sb += p[7:0];
                end
            end
            m.red = 8'(sr / (k * k));
            m.green = 8'(sg / (k * k));
            m.blue = 8'(sb / (k * k));
            m.col = 10'(col - (k - 1) / 2);
            m.row = 12'(row - (k - 1) / 2);
            m.last = end_col && end_row;
            expected_means.push_back(m);
        end
        if (end_col)
        begin
            next_col = 0;
            next_row = end_row ? 0 : row + 1;
        end
        else
        begin
            next_col = col + 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                pixel_item_t px;
                px = pending_pixels.pop_front();
                red_in <= px.red;
                green_in <= px.green;
                blue_in <= px.blue;
                frame_start <= px.first;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiver stops once for a long stretch after some results, so the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!rx_hold_done && results_seen >= 40)
        begin
            rx_hold_done <= 1'b1;
            rx_hold_left <= 600;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KERNEL: model_kernel = cfg_data[3:0];
                    REG_WIDTH:  model_width = cfg_data[10:0];
                    REG_HEIGHT: model_height = cfg_data[12:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_window_mean('{red_in, green_in, blue_in, frame_start});
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_means.size() == 0)
                begin
                    report_mismatch("unexpected item, col", center_col, -1);
                end
                else
                begin
                    window_mean_t m;
                    m = expected_means.pop_front();
                    if (red_mean !== m.red)
                        report_mismatch("red_mean", red_mean, m.red);
                    if (green_mean !== m.green)
                        report_mismatch("green_mean", green_mean, m.green);
                    if (blue_mean !== m.blue)
                        report_mismatch("blue_mean", blue_mean, m.blue);
                    if (center_col !== m.col)
                        report_mismatch("center_col", center_col, m.col);
                    if (center_row !== m.row)
                        report_mismatch("center_row", center_row, m.row);
                    if (frame_last !== m.last)
                        report_mismatch("frame_last", frame_last, m.last);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[rgb_box_mean_filter_top] ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_frames(input int kernel, input int width, input int height,
                              input int count, input int idle, input bit directed);
        pixel_item_t px;
        write_reg(REG_KERNEL, 13'(kernel));
        write_reg(REG_WIDTH, 13'(width));
        write_reg(REG_HEIGHT, 13'(height));
        idle_pct = idle;
        for (int i = 0; i < count; i++)
        begin
            if (directed)
            begin
                px.red = (i % 3 == 0) ? 8'hFF : 8'h00;
                px.green = (i % 2 == 1) ? 8'hFF : 8'h00;
                px.blue = (i < 8 || i > 19) ? 8'hFF : 8'h00;
            end
            else
            begin
                px.red = 8'($urandom_range(255));
                px.green = 8'($urandom_range(255));
                px.blue = 8'($urandom_range(255));
            end
            px.first = (i == 0) || (!directed && $urandom_range(199) == 0);
            pending_pixels.push_back(px);
        end
        while (pending_pixels.size() != 0 || in_valid || expected_means.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        run_frames(3, 4, 4, 25, 17, 1'b1);
        run_frames(0, 5, 3, 40, 17, 1'b0);
        run_frames(1, 3, 3, 30, 17, 1'b0);
        run_frames(4, 6, 5, 70, 17, 1'b0);
        run_frames(5, 7, 7, 80, 17, 1'b0);
        run_frames(15, 15, 15, 240, 17, 1'b0);
        run_frames(7, 0, 9, 20, 17, 1'b0);
        run_frames(6, 10, 0, 30, 17, 1'b0);
        run_frames(8, 9, 8, 100, 17, 1'b0);
        run_frames(10, 11, 9, 100, 17, 1'b0);
        run_frames(11, 12, 11, 100, 17, 1'b0);
        run_frames(14, 16, 14, 224, 17, 1'b0);
        run_frames(2, 24, 8191, 160, 0, 1'b0);
        run_frames(9, 10, 10, 100, 17, 1'b0);
        if (error_count == 0 && expected_means.size() == 0)
        begin
            $display("[rgb_box_mean_filter_top] OK");
        end
        else
        begin
            $display("[rgb_box_mean_filter_top] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/rbmf_pkg.sv
sv/rbmf_front.sv
sv/rbmf_queue.sv
sv/rbmf_back.sv
sv/rgb_box_mean_filter_top.sv
sv/rbmf_checker.sv
dv/rgb_box_mean_filter_top_test.sv
